FILE: hdl/ttc_pkg.sv
`timescale 1ns / 1ps
package ttc_pkg;

  // fixed field widths
  localparam int COORD_WIDTH     = 24;
  localparam int COORD_FRAC_BITS = 16;
  localparam int TRIG_WIDTH      = 16;
  localparam int TRIG_FRAC       = 14;
  localparam int SCALE_WIDTH     = 16;
  localparam int SIZE_WIDTH      = 11;
  localparam int SCR_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_Z         = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_Z         = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_X         = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_X         = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROJ_X_SCALE  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROJ_Y_SCALE  = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
  } triangle_t;

  typedef struct packed {
    logic                        visible;
    logic signed [SCR_WIDTH-1:0] s0_x;
    logic signed [SCR_WIDTH-1:0] s0_y;
    logic signed [SCR_WIDTH-1:0] s1_x;
    logic signed [SCR_WIDTH-1:0] s1_y;
    logic signed [SCR_WIDTH-1:0] s2_x;
    logic signed [SCR_WIDTH-1:0] s2_y;
  } screen_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] cos_z;
    logic signed [TRIG_WIDTH-1:0] sin_z;
    logic signed [TRIG_WIDTH-1:0] cos_x;
    logic signed [TRIG_WIDTH-1:0] sin_x;
    logic [SCALE_WIDTH-1:0]       proj_x_scale;
    logic [SCALE_WIDTH-1:0]       proj_y_scale;
    logic [SIZE_WIDTH-1:0]        screen_width;
    logic [SIZE_WIDTH-1:0]        screen_height;
  } cfg_t;

endpackage

FILE: hdl/triangle_transform_cull_project.sv
`timescale 1ns / 1ps
// Rotates a triangle about Z then X, pushes it 3 units forward, culls it
// when it faces away from a camera at the origin, and projects its three
// vertices to screen pixels. One triangle is taken every clock cycle and
// busy stays low. Each result appears with done high for one cycle. The
// pipeline is 4 rotation stages, NW + 5 projection stages (NW = VW + 17,
// the numerator width, with VW = max(COORD_WIDTH+7, FRAC_BITS+4) the width
// of a rotated coordinate, input coordinates being Q8.16 by default) and
// the output register. Most of that depth is the perspective divider,
// which resolves one quotient bit per stage across the numerator width. A
// hidden triangle returns visible low and all screen fields zero. Results
// cannot be held off, so the receiver must take every done beat.
module triangle_transform_cull_project import ttc_pkg::*; #(
  parameter int FRAC_BITS = COORD_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  triangle_t                  triangle,
  output logic                       done,
  output screen_t                    result,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);
  localparam int VW       = (COORD_WIDTH + 7 > FRAC_BITS + 4) ?
                            COORD_WIDTH + 7 : FRAC_BITS + 4;
  localparam int NW       = VW + SCALE_WIDTH + 1;
  localparam int ROT_LAT  = 4;
  localparam int CULL_LAT = 6;
  localparam int PROJ_LAT = NW + 5;
  localparam int TOTAL    = ROT_LAT + PROJ_LAT;
  localparam int VIS_DLY  = PROJ_LAT - CULL_LAT;

  cfg_t                        cfg;
  logic                        accept;
  logic [TOTAL-1:0]            vpipe;
  logic [VIS_DLY-1:0]          vis_d;
  logic                        vis_c, vis;
  logic signed [COORD_WIDTH-1:0] ix [3], iy [3], iz [3];
  logic signed [VW-1:0]        vx [3], vy [3], vz [3];
  logic signed [SCR_WIDTH-1:0] sx [3], sy [3];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_z         <= 16'sd16384;
      cfg.sin_z         <= '0;
      cfg.cos_x         <= 16'sd16384;
      cfg.sin_x         <= '0;
      cfg.proj_x_scale  <= 16'd16384;
      cfg.proj_y_scale  <= 16'd16384;
      cfg.screen_width  <= 11'd512;
      cfg.screen_height <= 11'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS_Z:         cfg.cos_z         <= cfg_data;
        REG_SIN_Z:         cfg.sin_z         <= cfg_data;
        REG_COS_X:         cfg.cos_x         <= cfg_data;
        REG_SIN_X:         cfg.sin_x         <= cfg_data;
        REG_PROJ_X_SCALE:  cfg.proj_x_scale  <= cfg_data;
        REG_PROJ_Y_SCALE:  cfg.proj_y_scale  <= cfg_data;
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[SIZE_WIDTH-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[SIZE_WIDTH-1:0];
      endcase
    end
  end

  // beat tracking through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[TOTAL-2:0], accept};
    end
  end

  assign ix[0] = triangle.v0_x;
  assign iy[0] = triangle.v0_y;
  assign iz[0] = triangle.v0_z;
  assign ix[1] = triangle.v1_x;
  assign iy[1] = triangle.v1_y;
  assign iz[1] = triangle.v1_z;
  assign ix[2] = triangle.v2_x;
  assign iy[2] = triangle.v2_y;
  assign iz[2] = triangle.v2_z;

  // one lane per vertex
  for (genvar k = 0; k < 3; k++) begin : g_lane
    ttc_rotate_lane #(
      .VW        (VW),
      .FRAC_BITS (FRAC_BITS)
    ) u_rot (
      .clk (clk),
      .cfg (cfg),
      .x   (ix[k]),
      .y   (iy[k]),
      .z   (iz[k]),
      .rx  (vx[k]),
      .ry  (vy[k]),
      .rz  (vz[k])
    );

    ttc_project_lane #(
      .VW        (VW),
      .FRAC_BITS (FRAC_BITS)
    ) u_proj_x (
      .clk   (clk),
      .c     (vx[k]),
      .z     (vz[k]),
      .scale (cfg.proj_x_scale),
      .size  (cfg.screen_width),
      .s     (sx[k])
    );

    ttc_project_lane #(
      .VW        (VW),
      .FRAC_BITS (FRAC_BITS)
    ) u_proj_y (
      .clk   (clk),
      .c     (vy[k]),
      .z     (vz[k]),
      .scale (cfg.proj_y_scale),
      .size  (cfg.screen_height),
      .s     (sy[k])
    );
  end

  ttc_cull #(
    .VW (VW)
  ) u_cull (
    .clk     (clk),
    .vx      (vx),
    .vy      (vy),
    .vz      (vz),
    .visible (vis_c)
  );

  // align the cull flag with the projected vertices
  always_ff @(posedge clk) begin
    vis_d <= {vis_d[VIS_DLY-2:0], vis_c};
  end

  assign vis = vis_d[VIS_DLY-1];

  // merge and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (vpipe[TOTAL-1]) begin
      result.visible <= vis;
      result.s0_x    <= vis ? sx[0] : '0;
      result.s0_y    <= vis ? sy[0] : '0;
      result.s1_x    <= vis ? sx[1] : '0;
      result.s1_y    <= vis ? sy[1] : '0;
      result.s2_x    <= vis ? sx[2] : '0;
      result.s2_y    <= vis ? sy[2] : '0;
    end
  end

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(TOTAL + 1) done)
    else $error("result beat missing after fixed latency");

  // hidden triangles carry zero screen fields
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.visible |-> result.s0_x == '0 && result.s0_y == '0 &&
      result.s1_x == '0 && result.s1_y == '0 &&
      result.s2_x == '0 && result.s2_y == '0)
    else $error("hidden triangle with nonzero screen fields");

  // width register takes the low bits of a write
  a_cfg_width: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index == REG_SCREEN_WIDTH |=>
      cfg.screen_width == $past(cfg_data[SIZE_WIDTH-1:0]))
    else $error("screen width write lost");

  // no beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat straight after reset");

endmodule

FILE: hdl/ttc_rotate_lane.sv
`timescale 1ns / 1ps
module ttc_rotate_lane import ttc_pkg::*; #(
  parameter int VW        = 31,
  parameter int FRAC_BITS = COORD_FRAC_BITS
) (
  input  logic                          clk,
  input  cfg_t                          cfg,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  output logic signed [VW-1:0]          rx,
  output logic signed [VW-1:0]          ry,
  output logic signed [VW-1:0]          rz
);
  localparam int W = COORD_WIDTH;
  localparam logic signed [VW-1:0] Z_PUSH = VW'(3) <<< FRAC_BITS;

  logic signed [W+15:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [W-1:0]  z1, z1b;
  logic signed [W+16:0] dx, dy;
  logic signed [W+2:0]  x1, y1, x1b;
  logic signed [W+18:0] q_yc, q_zs, q_ys, q_zc;
  logic signed [W+19:0] ey, ez;
  logic signed [W+5:0]  y2, z2;

  // z rotation products
  always_ff @(posedge clk) begin
    p_xc <= x * cfg.cos_z;
    p_ys <= y * cfg.sin_z;
    p_xs <= x * cfg.sin_z;
    p_yc <= y * cfg.cos_z;
    z1   <= z;
  end

  assign dx = p_xc - p_ys;
  assign dy = p_xs + p_yc;

  // floor by 2^14
  always_ff @(posedge clk) begin
    x1  <= dx[W+16:TRIG_FRAC];
    y1  <= dy[W+16:TRIG_FRAC];
    z1b <= z1;
  end

  // x rotation products
  always_ff @(posedge clk) begin
    q_yc <= y1 * cfg.cos_x;
    q_zs <= z1b * cfg.sin_x;
    q_ys <= y1 * cfg.sin_x;
    q_zc <= z1b * cfg.cos_x;
    x1b  <= x1;
  end

  assign ey = q_yc - q_zs;
  assign ez = q_ys + q_zc;
  assign y2 = ey[W+19:TRIG_FRAC];
  assign z2 = ez[W+19:TRIG_FRAC];

  // depth push
  always_ff @(posedge clk) begin
    rx <= VW'(x1b);
    ry <= VW'(y2);
    rz <= VW'(z2) + Z_PUSH;
  end

endmodule

FILE: hdl/ttc_cull.sv
`timescale 1ns / 1ps
module ttc_cull import ttc_pkg::*; #(
  parameter int VW = 31
) (
  input  logic                 clk,
  input  logic signed [VW-1:0] vx [3],
  input  logic signed [VW-1:0] vy [3],
  input  logic signed [VW-1:0] vz [3],
  output logic                 visible
);
  localparam int EW  = VW + 1;
  localparam int PW  = 2 * EW;
  localparam int NCW = PW + 1;
  localparam int LOW = NCW / 2;
  localparam int HW  = NCW - LOW;
  localparam int TW  = NCW + VW;
  localparam int SW  = TW + 2;

  logic signed [EW-1:0]    e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [VW-1:0]    a0x, a0y, a0z, b0x, b0y, b0z, c0x, c0y, c0z;
  logic signed [PW-1:0]    m0, m1, m2, m3, m4, m5;
  logic signed [NCW-1:0]   nx, ny, nz;
  logic signed [HW+VW-1:0] hx, hy, hz;
  logic signed [LOW+VW:0]  lx, ly, lz;
  logic signed [TW-1:0]    tx, ty, tz;
  logic signed [SW-1:0]    dot;

  // edges from vertex 0
  always_ff @(posedge clk) begin
    e1x <= EW'(vx[1]) - EW'(vx[0]);
    e1y <= EW'(vy[1]) - EW'(vy[0]);
    e1z <= EW'(vz[1]) - EW'(vz[0]);
    e2x <= EW'(vx[2]) - EW'(vx[0]);
    e2y <= EW'(vy[2]) - EW'(vy[0]);
    e2z <= EW'(vz[2]) - EW'(vz[0]);
    a0x <= vx[0];
    a0y <= vy[0];
    a0z <= vz[0];
  end

  // cross product terms
  always_ff @(posedge clk) begin
    m0  <= e1y * e2z;
    m1  <= e1z * e2y;
    m2  <= e1z * e2x;
    m3  <= e1x * e2z;
    m4  <= e1x * e2y;
    m5  <= e1y * e2x;
    b0x <= a0x;
    b0y <= a0y;
    b0z <= a0z;
  end

  // normal
  always_ff @(posedge clk) begin
    nx  <= NCW'(m0) - NCW'(m1);
    ny  <= NCW'(m2) - NCW'(m3);
    nz  <= NCW'(m4) - NCW'(m5);
    c0x <= b0x;
    c0y <= b0y;
    c0z <= b0z;
  end

  // dot with vertex 0, normal split in high and low halves
  always_ff @(posedge clk) begin
    hx <= $signed(nx[NCW-1:LOW]) * c0x;
    hy <= $signed(ny[NCW-1:LOW]) * c0y;
    hz <= $signed(nz[NCW-1:LOW]) * c0z;
    lx <= $signed({1'b0, nx[LOW-1:0]}) * c0x;
    ly <= $signed({1'b0, ny[LOW-1:0]}) * c0y;
    lz <= $signed({1'b0, nz[LOW-1:0]}) * c0z;
  end

  // recombine halves
  always_ff @(posedge clk) begin
    tx <= (TW'(hx) <<< LOW) + TW'(lx);
    ty <= (TW'(hy) <<< LOW) + TW'(ly);
    tz <= (TW'(hz) <<< LOW) + TW'(lz);
  end

  assign dot = SW'(tx) + SW'(ty) + SW'(tz);

  // facing camera when the dot product is negative
  always_ff @(posedge clk) begin
    visible <= dot[SW-1];
  end

endmodule

FILE: hdl/ttc_div.sv
`timescale 1ns / 1ps
module ttc_div import ttc_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int SW = 50
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic [DW:0]   rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]   rin;
    logic [NW-1:0] nin, qin;
    logic [DW-1:0] din;
    logic [SW-1:0] sin;
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign nin = num;
      assign qin = '0;
      assign din = den;
      assign sin = side;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign nin = num_r[i-1];
      assign qin = quo_r[i-1];
      assign din = den_r[i-1];
      assign sin = side_r[i-1];
    end

    assign shifted = {rin[DW-1:0], nin[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, din};
    assign ge      = ~diff[DW+1];

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? diff[DW:0] : shifted;
      num_r[i]  <= nin << 1;
      quo_r[i]  <= {qin[NW-2:0], ge};
      den_r[i]  <= din;
      side_r[i] <= sin;
    end
  end

  assign quo      = quo_r[NW-1];
  assign side_out = side_r[NW-1];

endmodule

FILE: hdl/ttc_project_lane.sv
`timescale 1ns / 1ps
module ttc_project_lane import ttc_pkg::*; #(
  parameter int VW        = 31,
  parameter int FRAC_BITS = COORD_FRAC_BITS
) (
  input  logic                        clk,
  input  logic signed [VW-1:0]        c,
  input  logic signed [VW-1:0]        z,
  input  logic [SCALE_WIDTH-1:0]      scale,
  input  logic [SIZE_WIDTH-1:0]       size,
  output logic signed [SCR_WIDTH-1:0] s
);
  localparam int NW = VW + SCALE_WIDTH + 1;
  localparam int PW = NW + 1;
  localparam int AW = NW + 2;
  localparam int MW = AW + SIZE_WIDTH + 1;
  localparam int SDW = NW + 2;
  localparam logic signed [AW-1:0] HALF   = AW'(16384);
  localparam logic signed [MW-1:0] ROUND  = MW'(32767);
  localparam logic signed [MW-1:0] S_MAX  = MW'(32767);
  localparam logic signed [MW-1:0] S_MIN  = -MW'(32768);

  logic signed [NW-1:0] num;
  logic signed [VW-1:0] z1;
  logic [NW-1:0]        nmag;
  logic [VW-1:0]        dmag;
  logic [SDW-1:0]       side, side_o;
  logic [NW-1:0]        quo;
  logic signed [NW-1:0] alt_o;
  logic signed [PW-1:0] qs, p;
  logic signed [MW-1:0] m, adj, t;

  // numerator
  always_ff @(posedge clk) begin
    num <= c * $signed({1'b0, scale});
    z1  <= z;
  end

  // magnitudes, sign and the zero-depth fallback
  always_ff @(posedge clk) begin
    nmag <= num[NW-1] ? NW'(-num) : NW'(num);
    dmag <= z1[VW-1] ? VW'(-z1) : VW'(z1);
    side <= {num[NW-1] ^ z1[VW-1], z1 == '0, NW'(num >>> FRAC_BITS)};
  end

  ttc_div #(
    .NW (NW),
    .DW (VW),
    .SW (SDW)
  ) u_div (
    .clk      (clk),
    .num      (nmag),
    .den      (dmag),
    .side     (side),
    .quo      (quo),
    .side_out (side_o)
  );

  assign qs    = $signed({1'b0, quo});
  assign alt_o = side_o[NW-1:0];

  // signed quotient, truncated toward zero
  always_ff @(posedge clk) begin
    if (side_o[NW]) begin
      p <= PW'(alt_o);
    end else begin
      p <= side_o[NW+1] ? -qs : qs;
    end
  end

  // viewport scale
  always_ff @(posedge clk) begin
    m <= (AW'(p) + HALF) * $signed({1'b0, size});
  end

  assign adj = m[MW-1] ? m + ROUND : m;
  assign t   = adj >>> 15;

  // truncate and saturate to 16 bits
  always_ff @(posedge clk) begin
    if (t > S_MAX) begin
      s <= S_MAX[SCR_WIDTH-1:0];
    end else if (t < S_MIN) begin
      s <= S_MIN[SCR_WIDTH-1:0];
    end else begin
      s <= t[SCR_WIDTH-1:0];
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import ttc_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int ITEMS_PER_SET = 100;
  localparam int NUM_SETS      = 8;

  typedef logic signed [127:0] wide_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  triangle_t triangle;
  logic      done;
  screen_t   result;
  logic      cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  // register image as seen by the predictor
  logic [CFG_DATA_WIDTH-1:0] reg_image [8];

  screen_t screens_due [$];
  int      mismatches;
  int      idle_cycles;
  bit      no_gaps;

  typedef struct {
    triangle_t tri_in;
    bit        literal;
    screen_t   want;
  } stim_row_t;

  stim_row_t stim_rows [$];

  triangle_transform_cull_project uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .triangle(triangle),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // full width product, as the cull test needs the 98 bits of the dot product at the default widths
  function automatic wide_t wide_mul(wide_t a, wide_t b);
    return a * b;
  endfunction

  // perspective divide and viewport scaling of one axis
  function automatic logic [SCR_WIDTH-1:0] screen_axis(longint c, longint z,
                                                       longint scale, longint size);
    longint p;
    longint s;
    if (z != 0) p = (c * scale) / z;
    else p = (c * scale) >>> COORD_FRAC_BITS;
    s = ((p + 16384) * size) / 32768;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[SCR_WIDTH-1:0];
  endfunction

  function automatic screen_t project_triangle(triangle_t t);
    longint cz, sz, cx, sx;
    longint pin [3][3];
    longint rot [3][3];
    longint e1 [3];
    longint e2 [3];
    longint x1, y1;
    wide_t  nx, ny, nz, dot;
    screen_t s;
    cz = longint'($signed(reg_image[REG_COS_Z]));
    sz = longint'($signed(reg_image[REG_SIN_Z]));
    cx = longint'($signed(reg_image[REG_COS_X]));
    sx = longint'($signed(reg_image[REG_SIN_X]));
    pin = '{'{t.v0_x, t.v0_y, t.v0_z}, '{t.v1_x, t.v1_y, t.v1_z},
            '{t.v2_x, t.v2_y, t.v2_z}};
    // rotate about z, then x, then push forward by 3.0
    for (int k = 0; k < 3; k++) begin
      x1 = (pin[k][0] * cz - pin[k][1] * sz) >>> TRIG_FRAC;
      y1 = (pin[k][0] * sz + pin[k][1] * cz) >>> TRIG_FRAC;
      rot[k][0] = x1;
      rot[k][1] = (y1 * cx - pin[k][2] * sx) >>> TRIG_FRAC;
      rot[k][2] = ((y1 * sx + pin[k][2] * cx) >>> TRIG_FRAC)
                  + (longint'(3) <<< COORD_FRAC_BITS);
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = rot[1][k] - rot[0][k];
      e2[k] = rot[2][k] - rot[0][k];
    end
    // facing test, exact
    nx = wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]);
    ny = wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]);
    nz = wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]);
    dot = wide_mul(nx, rot[0][0]) + wide_mul(ny, rot[0][1]) + wide_mul(nz, rot[0][2]);
    s = '0;
    if (dot < 0) begin
      s.visible = 1'b1;
      s.s0_x = screen_axis(rot[0][0], rot[0][2], reg_image[REG_PROJ_X_SCALE],
                           reg_image[REG_SCREEN_WIDTH]);
      s.s0_y = screen_axis(rot[0][1], rot[0][2], reg_image[REG_PROJ_Y_SCALE],
                           reg_image[REG_SCREEN_HEIGHT]);
      s.s1_x = screen_axis(rot[1][0], rot[1][2], reg_image[REG_PROJ_X_SCALE],
                           reg_image[REG_SCREEN_WIDTH]);
      s.s1_y = screen_axis(rot[1][1], rot[1][2], reg_image[REG_PROJ_Y_SCALE],
                           reg_image[REG_SCREEN_HEIGHT]);
      s.s2_x = screen_axis(rot[2][0], rot[2][2], reg_image[REG_PROJ_X_SCALE],
                           reg_image[REG_SCREEN_WIDTH]);
      s.s2_y = screen_axis(rot[2][1], rot[2][2], reg_image[REG_PROJ_Y_SCALE],
                           reg_image[REG_SCREEN_HEIGHT]);
    end
    return s;
  endfunction

  // mostly within +-4.0 so both windings and real projections occur
  function automatic logic [COORD_WIDTH-1:0] random_coord();
    if ($urandom_range(0, 7) == 0) return COORD_WIDTH'($urandom);
    return COORD_WIDTH'($urandom_range(0, 524288) - 262144);
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    t.v0_x = random_coord(); t.v0_y = random_coord(); t.v0_z = random_coord();
    t.v1_x = random_coord(); t.v1_y = random_coord(); t.v1_z = random_coord();
    t.v2_x = random_coord(); t.v2_y = random_coord(); t.v2_z = random_coord();
    return t;
  endfunction

  function automatic triangle_t make_triangle(int a0, int a1, int a2, int b0, int b1,
                                              int b2, int c0, int c1, int c2);
    triangle_t t;
    t = '{COORD_WIDTH'(a0), COORD_WIDTH'(a1), COORD_WIDTH'(a2),
          COORD_WIDTH'(b0), COORD_WIDTH'(b1), COORD_WIDTH'(b2),
          COORD_WIDTH'(c0), COORD_WIDTH'(c1), COORD_WIDTH'(c2)};
    return t;
  endfunction

  // called just after a rising edge, returns just after the accepting edge
  task automatic send_triangle(triangle_t t, bit literal, screen_t want);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9:             gap = $urandom_range(10, 40);
        default:       gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    triangle <= t;
    do @(negedge clk); while (busy);
    @(posedge clk);
    screens_due.push_back(literal ? want : project_triangle(t));
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    reg_image[idx] = (idx == REG_SCREEN_WIDTH || idx == REG_SCREEN_HEIGHT) ?
                     (val & 16'h07FF) : val;
  endtask

  // idle point: nothing outstanding
  task automatic wait_drained();
    start <= 1'b0;
    while (screens_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_setting(int set);
    logic [CFG_DATA_WIDTH-1:0] vals [8];
    case (set)
      1: vals = '{16'hC000, 16'h4000, 16'hC000, 16'hC000, 16'h0000, 16'hFFFF, 16'd1, 16'd1024};
      2: vals = '{16'h4000, 16'hC000, 16'h4000, 16'h4000, 16'hFFFF, 16'h0000, 16'd1024, 16'd1};
      3: vals = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h4000, 16'h4000, 16'd0, 16'hFFFF};
      default: begin
        for (int i = 0; i < 4; i++) begin
          vals[i] = CFG_DATA_WIDTH'($urandom_range(0, 32768) - 16384);
        end
        vals[4] = CFG_DATA_WIDTH'($urandom_range(8192, 40000));
        vals[5] = CFG_DATA_WIDTH'($urandom_range(8192, 40000));
        vals[6] = CFG_DATA_WIDTH'($urandom_range(1, 1024));
        vals[7] = CFG_DATA_WIDTH'($urandom_range(1, 1024));
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(CFG_INDEX_WIDTH'(i), vals[i]);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    rst = 1'b1; start = 1'b0; triangle = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; no_gaps = 1'b0;
    reg_image = '{16384, 0, 16384, 0, 16384, 16384, 512, 480};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: degenerate ones read straight off as hidden and zero
    stim_rows.push_back('{'0, 1'b1, '0});
    stim_rows.push_back('{{9{24'h7FFFFF}}, 1'b1, '0});
    stim_rows.push_back('{{9{24'h800000}}, 1'b1, '0});
    stim_rows.push_back('{{9{24'h555555}}, 1'b1, '0});
    stim_rows.push_back('{make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0), 1'b0, '0});
    stim_rows.push_back('{make_triangle(0, 0, 0, 0, 65536, 0, 65536, 0, 0), 1'b0, '0});
    // one vertex at zero depth
    stim_rows.push_back('{make_triangle(0, 0, 65536, 65536, 0, -196608, 0, 65536, 65536),
                          1'b0, '0});
    stim_rows.push_back('{make_triangle(0, 0, 65536, 0, 65536, -196608, 65536, 0, 65536),
                          1'b0, '0});
    stim_rows.push_back('{make_triangle(8388607, -8388608, 0, -8388608, 8388607, 8388607,
                                        0, 0, -8388608), 1'b0, '0});
    stim_rows.push_back('{make_triangle(-8388608, 8388607, 0, 8388607, -8388608, -8388608,
                                        0, 0, 8388607), 1'b0, '0});
    stim_rows.push_back('{{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                          24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555}, 1'b0, '0});
    stim_rows.push_back('{make_triangle(1, 0, -196608, 0, 1, -196608, 1, 1, -196607),
                          1'b0, '0});
    foreach (stim_rows[i]) send_triangle(stim_rows[i].tri_in, stim_rows[i].literal,
                                         stim_rows[i].want);

    // random part across register settings, sender drains before each write
    for (int set = 0; set < NUM_SETS; set++) begin
      if (set > 0) begin
        wait_drained();
        load_setting(set);
      end
      no_gaps = (set % 3 == 2);
      for (int n = 0; n < ITEMS_PER_SET; n++) send_triangle(random_triangle(), 1'b0, '0);
    end
    start <= 1'b0;

    while (screens_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && screens_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result check, sampled mid-cycle
  always @(negedge clk) begin
    screen_t want;
    if (!rst && done) begin
      if (screens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result);
      end else begin
        want = screens_due.pop_front();
        if (result.visible !== want.visible || result.s0_x !== want.s0_x ||
            result.s0_y !== want.s0_y || result.s1_x !== want.s1_x ||
            result.s1_y !== want.s1_y || result.s2_x !== want.s2_x ||
            result.s2_y !== want.s2_y) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(negedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
